// ===== hdl/t2i128_pkg.sv =====
package t2i128_pkg;

  localparam int DEFAULT_MAX_HEX_DIGITS = 32;

  localparam int CHAR_W   = 16;
  localparam int HALF_W   = 64;
  localparam int ACC_W    = 2 * HALF_W;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = ((2 * HALF_W + 1 + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SELECT = 1'b0,
    CFG_SIGNED_MODE = 1'b1
  } cfg_index_t;

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 16'h002D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 16'h0030;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 16'h0039;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 16'h0046;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 16'h0066;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t   r;
    logic [CHAR_W-1:0] t;
    r = '0;
    t = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      r.valid = 1'b1;
      r.value = t[3:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      t = c - CHAR_UPPER_A + 16'd10;
      r.valid = 1'b1;
      r.value = t[3:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      t = c - CHAR_LOWER_A + 16'd10;
      r.valid = 1'b1;
      r.value = t[3:0];
    end
    return r;
  endfunction

  function automatic logic is_dec_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== hdl/text_to_int128_converter.sv =====
// Text to 128-bit integer converter. Characters arrive one per beat on the
// s_ side (16-bit code in s_tdata, s_tlast on the final character); one
// result beat per string leaves on the m_ side when the final character has
// been taken. Decimal mode accumulates acc*10+digit modulo 2^128 and, with
// signed_mode set, takes one minus sign anywhere and negates at the end; hex
// mode shifts in up to MAX_HEX_DIGITS digits. Any bad character makes the
// string fail, which returns zero with parse_ok low. The block takes one
// character every cycle unless a last character waits on a stalled output.
// An input register feeds the accumulator update (one 128-bit shift-add),
// and the final negation has its own stage before the output register.
// Registers are to be written on cfg_we only while the block is idle; the block does not enforce this.
module text_to_int128_converter #(
  parameter int MAX_HEX_DIGITS = t2i128_pkg::DEFAULT_MAX_HEX_DIGITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [t2i128_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [t2i128_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [t2i128_pkg::S_DATA_W-1:0]    s_tdata,   // char_code
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [t2i128_pkg::M_DATA_W-1:0]    m_tdata    // value_low, value_high, parse_ok
);
  import t2i128_pkg::*;

  localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HEX_DIGITS);

  logic base_select;
  logic signed_mode;

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  logic [ACC_W-1:0] acc;
  logic             minus_seen;
  logic             error_seen;
  logic [CNT_W-1:0] hex_count;

  logic [ACC_W-1:0] acc_next;
  logic             minus_next;
  logic             error_next;
  logic [CNT_W-1:0] hex_count_next;

  logic             fin_valid;
  logic [ACC_W-1:0] fin_acc;
  logic             fin_minus;
  logic             fin_error;

  logic [HALF_W-1:0] value_low;
  logic [HALF_W-1:0] value_high;
  logic              parse_ok;

  logic out_free;
  logic fin_free;
  logic in_go;

  hex_digit_t       hd;
  logic [ACC_W-1:0] acc_x10;
  logic [ACC_W-1:0] dec_digit;
  logic [CNT_W-1:0] cnt_inc;
  logic [ACC_W-1:0] fin_neg;

  assign out_free = !m_tvalid || m_tready;
  assign fin_free = !fin_valid || out_free;
  assign in_go    = in_valid && (fin_free || !in_last);
  assign s_tready = !in_valid || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= 1'b0;
      signed_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_BASE_SELECT: base_select <= cfg_data[0];
        CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata[CHAR_W-1:0];
      in_last <= s_tlast;
    end
  end

  always_comb begin
    hd        = hex_decode(in_char);
    acc_x10   = {acc[ACC_W-4:0], 3'b000} + {acc[ACC_W-2:0], 1'b0};
    dec_digit = ACC_W'(in_char[3:0]);
    cnt_inc   = (hex_count <= CNT_MAX) ? hex_count + CNT_W'(1) : hex_count;

    acc_next       = acc;
    minus_next     = minus_seen;
    error_next     = error_seen;
    hex_count_next = hex_count;
    if (!error_seen) begin
      if (base_select) begin
        hex_count_next = cnt_inc;
        if (cnt_inc > CNT_MAX || !hd.valid) begin
          error_next = 1'b1;
        end else begin
          acc_next = {acc[ACC_W-5:0], hd.value};
        end
      end else begin
        priority if (in_char == CHAR_MINUS && signed_mode && !minus_seen) begin
          minus_next = 1'b1;
        end else if (!is_dec_digit(in_char)) begin
          error_next = 1'b1;
        end else begin
          acc_next = acc_x10 + dec_digit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      minus_seen <= 1'b0;
      error_seen <= 1'b0;
      hex_count  <= '0;
    end else if (in_go) begin
      if (in_last) begin
        acc        <= '0;
        minus_seen <= 1'b0;
        error_seen <= 1'b0;
        hex_count  <= '0;
      end else begin
        acc        <= acc_next;
        minus_seen <= minus_next;
        error_seen <= error_next;
        hex_count  <= hex_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_free) begin
      fin_valid <= in_go && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_free && in_go && in_last) begin
      fin_acc   <= acc_next;
      fin_minus <= minus_next;
      fin_error <= error_next;
    end
  end

  always_comb begin
    fin_neg = ~fin_acc + ACC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) begin
      if (fin_error) begin
        value_low  <= '0;
        value_high <= '0;
        parse_ok   <= 1'b0;
      end else if (fin_minus) begin
        value_low  <= fin_neg[HALF_W-1:0];
        value_high <= fin_neg[ACC_W-1:HALF_W];
        parse_ok   <= 1'b1;
      end else begin
        value_low  <= fin_acc[HALF_W-1:0];
        value_high <= fin_acc[ACC_W-1:HALF_W];
        parse_ok   <= 1'b1;
      end
    end
  end

  assign m_tdata = {(M_DATA_W - ACC_W - 1)'(0), parse_ok, value_high, value_low};

endmodule
